[src/sta_lta_seismic_event_detector_top_assert.svh]
// assertion macros used by the checker file of the detector
`ifndef STA_LTA_SEISMIC_EVENT_DETECTOR_TOP_ASSERT_SVH
`define STA_LTA_SEISMIC_EVENT_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SLD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sta_lta detector check failed");

// next-cycle implication, disabled while reset is asserted
`define SLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sta_lta detector check failed");

`endif

[src/sld_pkg.sv]
// shared types, codes and constants of the sta/lta event detector
package sld_pkg;

	localparam int LONG_WINDOW_DEF  = 32;
	localparam int SHORT_WINDOW_DEF = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MINOR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODERATE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEVERE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTREME  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = 3'd6;

	// configuration reset values
	localparam logic signed [14:0] GRAVITY_RST  = 15'sd1000;
	localparam logic [15:0]        MINOR_RST    = 16'd30;
	localparam logic [15:0]        MODERATE_RST = 16'd60;
	localparam logic [15:0]        SEVERE_RST   = 16'd100;
	localparam logic [15:0]        EXTREME_RST  = 16'd150;
	localparam logic [3:0]         TRIGGER_RST  = 4'd3;
	localparam logic [3:0]         RELEASE_RST  = 4'd2;

	localparam logic [15:0] RING_INIT = 16'd5;

	// alert levels
	localparam logic [2:0] LVL_NONE     = 3'd0;
	localparam logic [2:0] LVL_MINOR    = 3'd1;
	localparam logic [2:0] LVL_MODERATE = 3'd2;
	localparam logic [2:0] LVL_SEVERE   = 3'd3;
	localparam logic [2:0] LVL_EXTREME  = 3'd4;

	// square root of a 34 bit radicand, one result bit per step
	localparam int                SQRT_CNT_W = 5;
	localparam logic [SQRT_CNT_W-1:0] SQRT_LAST = 5'd16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_Z,
		ST_SQ_ACC,
		ST_SQRT,
		ST_WRITE,
		ST_SHORT,
		ST_SHORT_LAST,
		ST_DIV_S,
		ST_DIV_L,
		ST_DIV_END,
		ST_DECIDE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		MUL_X,
		MUL_Y,
		MUL_Z,
		MUL_STA,
		MUL_LTA
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     rd_old;
		mul_sel_t mul_sel;
		logic     acc_add;
		logic     sqrt_step;
		logic     write;
		logic     rd_short;
		logic     cap_sta;
		logic     cap_lta;
		logic     commit;
	} dp_cmd_t;

	typedef struct packed {
		logic sqrt_last;
		logic short_last;
	} dp_sts_t;

endpackage

[src/sld_datapath.sv]
// datapath: squares, iterative square root, magnitude ring, averages and event bookkeeping
module sld_datapath #(
	parameter int LONG_WINDOW  = sld_pkg::LONG_WINDOW_DEF,
	parameter int SHORT_WINDOW = sld_pkg::SHORT_WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sld_pkg::dp_cmd_t                cmd,
	output sld_pkg::dp_sts_t                sts,
	input  logic                            cfg_we,
	input  logic [sld_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sld_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic signed [15:0]              accel_x,
	input  logic signed [15:0]              accel_y,
	input  logic signed [15:0]              accel_z,
	output logic [15:0]                     magnitude,
	output logic [15:0]                     short_average,
	output logic [15:0]                     long_average,
	output logic [2:0]                      alert_level,
	output logic                            event_active,
	output logic                            event_started,
	output logic                            event_ended,
	output logic [15:0]                     event_peak,
	output logic [31:0]                     event_length,
	output logic [31:0]                     event_total,
	output logic                            new_maximum,
	output logic                            intensity_rising
);
	import sld_pkg::*;

	localparam int PTR_W  = (LONG_WINDOW > 1) ? $clog2(LONG_WINDOW) : 1;
	localparam int RS_W   = $clog2(LONG_WINDOW * 65535 + 1);
	localparam int SS_W   = $clog2(SHORT_WINDOW * 65535 + 1);
	localparam int SC_W   = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
	// reciprocal multipliers, exact for every sum below 2**width
	localparam int STA_SH = SS_W + $clog2(SHORT_WINDOW);
	localparam int LTA_SH = RS_W + $clog2(LONG_WINDOW);
	localparam longint unsigned STA_RECIP =
		((64'd1 << STA_SH) + SHORT_WINDOW - 1) / SHORT_WINDOW;
	localparam longint unsigned LTA_RECIP =
		((64'd1 << LTA_SH) + LONG_WINDOW - 1) / LONG_WINDOW;
	localparam int OPW    = ((RS_W > SS_W) ? RS_W : SS_W) + 1;
	localparam int PW     = 2 * OPW;
	localparam logic [RS_W-1:0] RSUM_RST = RS_W'(LONG_WINDOW * int'(RING_INIT));

	// configuration
	logic signed [14:0] grav_q;
	logic [15:0]        minor_q, moderate_q, severe_q, extreme_q;
	logic [3:0]         trig_q, rel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q     <= GRAVITY_RST;
			minor_q    <= MINOR_RST;
			moderate_q <= MODERATE_RST;
			severe_q   <= SEVERE_RST;
			extreme_q  <= EXTREME_RST;
			trig_q     <= TRIGGER_RST;
			rel_q      <= RELEASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRAVITY:  grav_q     <= $signed(cfg_data[14:0]);
				CFG_MINOR:    minor_q    <= cfg_data;
				CFG_MODERATE: moderate_q <= cfg_data;
				CFG_SEVERE:   severe_q   <= cfg_data;
				CFG_EXTREME:  extreme_q  <= cfg_data;
				CFG_TRIGGER:  trig_q     <= cfg_data[3:0];
				CFG_RELEASE:  rel_q      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// absolute axis deviations
	logic signed [16:0] dx, dy, dz;
	logic [16:0]        dx_abs, dy_abs, dz_abs;

	assign dx     = 17'(accel_x);
	assign dy     = 17'(accel_y);
	assign dz     = 17'(accel_z) - 17'(grav_q);
	assign dx_abs = dx[16] ? 17'(-dx) : 17'(dx);
	assign dy_abs = dy[16] ? 17'(-dy) : 17'(dy);
	assign dz_abs = dz[16] ? 17'(-dz) : 17'(dz);

	logic [15:0] ax_q, ay_q, az_q;

	// ring sum and short window sum, both feed the shared multiplier
	logic [RS_W-1:0] rsum_q;
	logic [SS_W-1:0] short_q;

	// shared multiplier, result registered
	logic [OPW-1:0] mul_a, mul_b;
	logic [PW-1:0]  prod_q;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_X: begin
				mul_a = OPW'(ax_q);
				mul_b = OPW'(ax_q);
			end
			MUL_Y: begin
				mul_a = OPW'(ay_q);
				mul_b = OPW'(ay_q);
			end
			MUL_Z: begin
				mul_a = OPW'(az_q);
				mul_b = OPW'(az_q);
			end
			MUL_STA: begin
				mul_a = OPW'(short_q);
				mul_b = OPW'(STA_RECIP);
			end
			MUL_LTA: begin
				mul_a = OPW'(rsum_q);
				mul_b = OPW'(LTA_RECIP);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// square root
	logic [33:0]           acc_q;
	logic [17:0]           rem_q;
	logic [16:0]           root_q;
	logic [SQRT_CNT_W-1:0] sqrt_cnt_q;
	logic [19:0]           rem_sh, trial;
	logic                  fits;
	logic [15:0]           mag_w;

	assign rem_sh = {rem_q, acc_q[33:32]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = (rem_sh >= trial);
	assign mag_w  = root_q[16] ? 16'hFFFF : root_q[15:0];

	// magnitude ring
	logic [15:0]            ring_mem [0:LONG_WINDOW-1];
	logic [LONG_WINDOW-1:0] vld_q;
	logic [PTR_W-1:0]       wp_q, ra_q, raddr;
	logic [15:0]            rd_data_q, rd_word;
	logic                   rd_vld_q, dv_q, rd_en;
	logic [SC_W-1:0]        sc_q;

	assign rd_en   = cmd.rd_old | cmd.rd_short;
	assign raddr   = cmd.rd_short ? ra_q : wp_q;
	assign rd_word = rd_vld_q ? rd_data_q : RING_INIT;

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			ring_mem[wp_q] <= mag_w;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[raddr];
		end
	end

	// averages
	logic [PW-1:0] sta_full, lta_full;
	logic [15:0]   sta_q, lta_q;

	assign sta_full = prod_q >> STA_SH;
	assign lta_full = prod_q >> LTA_SH;

	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
		if (cmd.load) begin
			ax_q   <= dx_abs[15:0];
			ay_q   <= dy_abs[15:0];
			az_q   <= dz_abs[15:0];
			acc_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.acc_add) begin
			acc_q <= acc_q + 34'(prod_q[31:0]);
		end
		if (cmd.sqrt_step) begin
			acc_q <= {acc_q[31:0], 2'b00};
			if (fits) begin
				rem_q  <= 18'(rem_sh - trial);
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[17:0];
				root_q <= {root_q[15:0], 1'b0};
			end
		end
		if (cmd.write) begin
			ra_q    <= wp_q;
			short_q <= '0;
		end else if (dv_q) begin
			short_q <= short_q + SS_W'(rd_word);
		end
		if (cmd.rd_short) begin
			ra_q <= (ra_q == '0) ? PTR_W'(LONG_WINDOW - 1) : ra_q - 1'b1;
		end
		if (cmd.cap_sta) begin
			sta_q <= sta_full[15:0];
		end
		if (cmd.cap_lta) begin
			lta_q <= (lta_full[15:0] == 16'd0) ? 16'd1 : lta_full[15:0];
		end
	end

	// event decision on the finished magnitude and averages
	logic [2:0]  lvl;
	logic [19:0] trig_lim, rel_lim;
	logic        in_evt_q, started, act, act_n, ended, newmax, rising;
	logic [2:0]  prev_q;
	logic [31:0] dur_q, dur_n, cnt_q, cnt_n;
	logic [15:0] peak_q, peak_n, rec_q, rec_n;

	assign trig_lim = 20'(lta_q) * 20'(trig_q);
	assign rel_lim  = 20'(lta_q) * 20'(rel_q);

	always_comb begin
		priority if (mag_w >= extreme_q) lvl = LVL_EXTREME;
		else if (mag_w >= severe_q)      lvl = LVL_SEVERE;
		else if (mag_w >= moderate_q)    lvl = LVL_MODERATE;
		else if (mag_w >= minor_q)       lvl = LVL_MINOR;
		else                             lvl = LVL_NONE;
	end

	always_comb begin
		started = !in_evt_q && ((lvl != LVL_NONE) || (20'(sta_q) > trig_lim));
		act     = in_evt_q || started;
		act_n   = act;
		dur_n   = started ? 32'd0 : dur_q;
		peak_n  = started ? mag_w : peak_q;
		cnt_n   = cnt_q + 32'(started);
		rec_n   = rec_q;
		ended   = 1'b0;
		newmax  = 1'b0;
		rising  = 1'b0;
		if (act) begin
			dur_n  = dur_n + 32'd1;
			if (mag_w > peak_n) begin
				peak_n = mag_w;
			end
			rising = (lvl > prev_q) && (lvl > LVL_MINOR);
			if ((lvl == LVL_NONE) && (20'(sta_q) <= rel_lim)) begin
				act_n = 1'b0;
				ended = 1'b1;
				if (peak_n > rec_q) begin
					rec_n  = peak_n;
					newmax = 1'b1;
				end
			end
		end
	end

	// control and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_q   <= 1'b0;
			dv_q       <= 1'b0;
			wp_q       <= '0;
			rsum_q     <= RSUM_RST;
			sqrt_cnt_q <= '0;
			sc_q       <= '0;
			in_evt_q   <= 1'b0;
			prev_q     <= LVL_NONE;
			dur_q      <= '0;
			peak_q     <= '0;
			cnt_q      <= '0;
			rec_q      <= '0;
		end else begin
			dv_q <= cmd.rd_short;
			if (rd_en) begin
				rd_vld_q <= vld_q[raddr];
			end
			if (cmd.load) begin
				sqrt_cnt_q <= '0;
			end else if (cmd.sqrt_step) begin
				sqrt_cnt_q <= sqrt_cnt_q + 1'b1;
			end
			if (cmd.write) begin
				vld_q[wp_q] <= 1'b1;
				// old entry still sits in the read register from the first square step
				rsum_q      <= rsum_q - RS_W'(rd_word) + RS_W'(mag_w);
				wp_q        <= (wp_q == PTR_W'(LONG_WINDOW - 1)) ? '0 : wp_q + 1'b1;
				sc_q        <= '0;
			end else if (cmd.rd_short) begin
				sc_q <= sc_q + 1'b1;
			end
			if (cmd.commit) begin
				in_evt_q <= act_n;
				prev_q   <= lvl;
				dur_q    <= dur_n;
				peak_q   <= peak_n;
				cnt_q    <= cnt_n;
				rec_q    <= rec_n;
			end
		end
	end

	assign sts.sqrt_last  = (sqrt_cnt_q == SQRT_LAST);
	assign sts.short_last = (sc_q == SC_W'(SHORT_WINDOW - 1));

	// output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			magnitude        <= mag_w;
			short_average    <= sta_q;
			long_average     <= lta_q;
			alert_level      <= lvl;
			event_active     <= act_n;
			event_started    <= started;
			event_ended      <= ended;
			event_peak       <= peak_n;
			event_length     <= dur_n;
			event_total      <= cnt_n;
			new_maximum      <= newmax;
			intensity_rising <= rising;
		end
	end

endmodule

[src/sld_ctrl.sv]
// controller: sequences one sample through the datapath and owns the input and output handshakes
module sld_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  sld_pkg::dp_sts_t sts,
	output sld_pkg::dp_cmd_t cmd
);
	import sld_pkg::*;

	ctrl_state_t state_q, state_n;
	logic        out_valid_q, out_valid_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		cmd         = '0;
		cmd.mul_sel = MUL_X;
		in_stall    = (state_q != ST_IDLE);
		out_valid_n = out_valid_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_SQ_X;
				end
			end
			ST_SQ_X: begin
				cmd.rd_old  = 1'b1;
				cmd.mul_sel = MUL_X;
				state_n     = ST_SQ_Y;
			end
			ST_SQ_Y: begin
				cmd.mul_sel = MUL_Y;
				cmd.acc_add = 1'b1;
				state_n     = ST_SQ_Z;
			end
			ST_SQ_Z: begin
				cmd.mul_sel = MUL_Z;
				cmd.acc_add = 1'b1;
				state_n     = ST_SQ_ACC;
			end
			ST_SQ_ACC: begin
				cmd.acc_add = 1'b1;
				state_n     = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_last) begin
					state_n = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_n   = ST_SHORT;
			end
			ST_SHORT: begin
				cmd.rd_short = 1'b1;
				if (sts.short_last) begin
					state_n = ST_SHORT_LAST;
				end
			end
			ST_SHORT_LAST: begin
				// last read beat lands in the short sum here
				state_n = ST_DIV_S;
			end
			ST_DIV_S: begin
				cmd.mul_sel = MUL_STA;
				state_n     = ST_DIV_L;
			end
			ST_DIV_L: begin
				cmd.mul_sel = MUL_LTA;
				cmd.cap_sta = 1'b1;
				state_n     = ST_DIV_END;
			end
			ST_DIV_END: begin
				cmd.cap_lta = 1'b1;
				state_n     = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.commit  = 1'b1;
					out_valid_n = 1'b1;
					state_n     = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[src/sta_lta_seismic_event_detector_top.sv]
// top level of the sta/lta seismic event detector
//
//  channel  direction  handshake             beat contents
//  in       sink       in_valid / in_stall   accel_x, accel_y, accel_z
//  out      source     out_valid / out_stall magnitude, averages, level, event fields
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one sample is processed at a time: a new input is taken only after the last result has been
// committed to the output register, and the time goes to the shared multiplier, the 17 step
// square root and one ring read per short window entry
// reset clears the ring valid bits at once, unwritten entries read as five, no clearing pass
// a stalled result stays in the output register; the next sample runs on behind it and
// waits in its last step until the register is free
module sta_lta_seismic_event_detector_top #(
	parameter int LONG_WINDOW  = sld_pkg::LONG_WINDOW_DEF,
	parameter int SHORT_WINDOW = sld_pkg::SHORT_WINDOW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [15:0]              accel_x,
	input  logic signed [15:0]              accel_y,
	input  logic signed [15:0]              accel_z,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [15:0]                     magnitude,
	output logic [15:0]                     short_average,
	output logic [15:0]                     long_average,
	output logic [2:0]                      alert_level,
	output logic                            event_active,
	output logic                            event_started,
	output logic                            event_ended,
	output logic [15:0]                     event_peak,
	output logic [31:0]                     event_length,
	output logic [31:0]                     event_total,
	output logic                            new_maximum,
	output logic                            intensity_rising,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sld_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sld_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sld_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	sld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sld_datapath #(
		.LONG_WINDOW  (LONG_WINDOW),
		.SHORT_WINDOW (SHORT_WINDOW)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.accel_x          (accel_x),
		.accel_y          (accel_y),
		.accel_z          (accel_z),
		.magnitude        (magnitude),
		.short_average    (short_average),
		.long_average     (long_average),
		.alert_level      (alert_level),
		.event_active     (event_active),
		.event_started    (event_started),
		.event_ended      (event_ended),
		.event_peak       (event_peak),
		.event_length     (event_length),
		.event_total      (event_total),
		.new_maximum      (new_maximum),
		.intensity_rising (intensity_rising)
	);

endmodule

[src/sld_checker.sv]
// port-level checker of the detector and its bind to the top level
`include "sta_lta_seismic_event_detector_top_assert.svh"

module sld_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [15:0]                     magnitude,
	input logic [15:0]                     long_average,
	input logic                            event_active,
	input logic                            event_started,
	input logic                            event_ended,
	input logic [31:0]                     event_length,
	input logic [31:0]                     event_total,
	input logic                            new_maximum
);

	// a stalled result beat holds
	`SLD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(magnitude) && $stable(event_total))

	// one sample at a time: an accepted beat stalls the next cycle
	`SLD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// a fresh event counts exactly the sample that started it
	`SLD_ASSERT_NOW(a_start_length, clk, arst_n, out_valid && event_started, event_length == 32'd1)

	// a new record only comes with the close of an event
	`SLD_ASSERT_NOW(a_newmax_end, clk, arst_n, out_valid && new_maximum, event_ended && !event_active)

	// long average never drops to zero
	`SLD_ASSERT_NOW(a_lta_nonzero, clk, arst_n, out_valid, long_average != 16'd0)

endmodule

bind sta_lta_seismic_event_detector_top sld_checker u_sld_checker (.*);
